// ===== design/fprr_pkg.sv =====
// ----------------------------------------------------------------------------
// fprr_pkg
// Shared types and constants of the framed parameter receiver and reporter.
// ----------------------------------------------------------------------------
package fprr_pkg;

   localparam int PARAM_COUNT_DEFAULT   = 16;
   localparam int SPECIAL_COUNT_DEFAULT = 4;

   localparam logic [7:0] FRAME_START  = 8'd7;
   localparam logic [7:0] FRAME_STOP   = 8'd8;
   localparam int         WINDOW_DEPTH = 9;
   localparam int         HELD_W       = $clog2(WINDOW_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] KIND_STORED  = 2'd0;
   localparam logic [1:0] KIND_DROPPED = 2'd1;
   localparam logic [1:0] KIND_REPORT  = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [7:0]  rx_byte;
      logic [31:0] tick_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] param_index;
      logic [31:0]        param_value;
      logic [31:0]        report_time;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_STORE_PARAM,
      CMD_STORE_SPECIAL,
      CMD_DROP,
      CMD_REPORT
   } cmd_op_type;

   // For reports, data carries the tick time; otherwise the frame's value word.
   typedef struct packed {
      cmd_op_type  op;
      logic [31:0] index;
      logic [31:0] data;
   } cmd_type;

endpackage

// ===== design/fprr_front.sv =====
// ----------------------------------------------------------------------------
// fprr_front
// Accepts items, runs the byte window deframer and classifies each frame
// or report tick into a command for the back end.
// ----------------------------------------------------------------------------
module fprr_front #(
   parameter int PARAM_COUNT   = fprr_pkg::PARAM_COUNT_DEFAULT,
   parameter int SPECIAL_COUNT = fprr_pkg::SPECIAL_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fprr_pkg::req_type req_payload,
   input  logic              queue_full,
   output logic              push_valid,
   output fprr_pkg::cmd_type push_cmd
);
   import fprr_pkg::*;

   logic [7:0]        win_ff [WINDOW_DEPTH];
   logic [HELD_W-1:0] held_ff;
   logic [HELD_W-1:0] held_in;

   logic        accept;
   logic        is_byte;
   logic        frame_hit;
   logic [31:0] frame_index;
   logic [31:0] frame_value;
   logic [31:0] frame_slot;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_byte   = (req_payload.operation == OP_BYTE);

   assign frame_hit = (held_ff == HELD_W'(WINDOW_DEPTH)) && (win_ff[0] == FRAME_START) &&
                      (req_payload.rx_byte == FRAME_STOP);
   assign frame_index = {win_ff[4], win_ff[3], win_ff[2], win_ff[1]};
   assign frame_value = {win_ff[8], win_ff[7], win_ff[6], win_ff[5]};
   assign frame_slot  = ~frame_index;

   assign push_valid = accept && (!is_byte || frame_hit);

   always_comb begin
      push_cmd = '{op: CMD_REPORT, index: '0, data: req_payload.tick_time};
      if (is_byte) begin
         push_cmd.index = frame_index;
         push_cmd.data  = frame_value;
         if (!frame_index[31] && (frame_index < 32'(PARAM_COUNT))) begin
            push_cmd.op = CMD_STORE_PARAM;
         end else if (frame_index[31] && (frame_slot < 32'(SPECIAL_COUNT))) begin
            push_cmd.op = CMD_STORE_SPECIAL;
         end else begin
            push_cmd.op = CMD_DROP;
         end
      end
   end

   always_comb begin
      held_in = held_ff;
      if (accept && is_byte) begin
         if (frame_hit) begin
            held_in = '0;
         end else if (held_ff < HELD_W'(WINDOW_DEPTH)) begin
            held_in = held_ff + HELD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // A full window drops its oldest byte; otherwise the byte fills the next slot.
   always_ff @(posedge clock) begin
      if (accept && is_byte && !frame_hit) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (held_ff >= HELD_W'(WINDOW_DEPTH)) begin
               if (i == WINDOW_DEPTH - 1) begin
                  win_ff[i] <= req_payload.rx_byte;
               end else begin
                  win_ff[i] <= win_ff[i + 1];
               end
            end else if (held_ff == HELD_W'(i)) begin
               win_ff[i] <= req_payload.rx_byte;
            end
         end
      end
   end

endmodule

// ===== design/fprr_queue.sv =====
// ----------------------------------------------------------------------------
// fprr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module fprr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  fprr_pkg::cmd_type push_cmd,
   output logic              queue_full,
   output logic              pop_valid,
   output fprr_pkg::cmd_type pop_cmd,
   input  logic              pop
);
   import fprr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push;
   logic              do_pop;

   assign queue_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/fprr_back.sv =====
// ----------------------------------------------------------------------------
// fprr_back
// Executes commands: writes the parameter and special stores, walks the
// report cursor and holds the result item in an output register.
// ----------------------------------------------------------------------------
module fprr_back #(
   parameter int PARAM_COUNT   = fprr_pkg::PARAM_COUNT_DEFAULT,
   parameter int SPECIAL_COUNT = fprr_pkg::SPECIAL_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  fprr_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fprr_pkg::rsp_type rsp_payload
);
   import fprr_pkg::*;

   localparam int P_AW  = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
   localparam int S_AW  = (SPECIAL_COUNT > 1) ? $clog2(SPECIAL_COUNT) : 1;
   localparam int MAX_C = (PARAM_COUNT > SPECIAL_COUNT) ? PARAM_COUNT : SPECIAL_COUNT;
   localparam int CUR_W = $clog2(MAX_C) + 1;

   logic [31:0]             param_mem   [PARAM_COUNT];
   logic [31:0]             special_mem [SPECIAL_COUNT];
   logic [PARAM_COUNT-1:0]  param_vld_ff;
   logic [SPECIAL_COUNT-1:0] special_vld_ff;

   logic signed [CUR_W-1:0] cur_ff;
   logic signed [CUR_W-1:0] cur_in;
   logic [CUR_W-1:0]        cur_inv;
   logic [P_AW-1:0]         cur_param_addr;
   logic [S_AW-1:0]         cur_special_addr;
   logic [P_AW-1:0]         wr_param_addr;
   logic [31:0]             wr_slot;
   logic [S_AW-1:0]         wr_special_addr;

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [31:0] index_ff;
   logic [31:0] data_ff;
   logic [31:0] time_ff;
   logic        from_param_ff;
   logic        from_special_ff;
   logic [31:0] param_rd_ff;
   logic        param_rdv_ff;
   logic [31:0] special_rd_ff;
   logic        special_rdv_ff;

   logic is_report;
   logic wr_param;
   logic wr_special;

   assign cmd_pop    = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign is_report  = (cmd.op == CMD_REPORT);
   assign wr_param   = cmd_pop && (cmd.op == CMD_STORE_PARAM);
   assign wr_special = cmd_pop && (cmd.op == CMD_STORE_SPECIAL);

   assign cur_inv          = ~cur_ff;
   assign cur_param_addr   = cur_ff[P_AW-1:0];
   assign cur_special_addr = cur_inv[S_AW-1:0];
   assign wr_param_addr    = cmd.index[P_AW-1:0];
   assign wr_slot          = ~cmd.index;
   assign wr_special_addr  = wr_slot[S_AW-1:0];

   always_comb begin
      cur_in = cur_ff;
      if (cmd_pop && is_report) begin
         if (cur_ff == CUR_W'(PARAM_COUNT - 1)) begin
            cur_in = CUR_W'(-SPECIAL_COUNT);
         end else begin
            cur_in = cur_ff + $signed(CUR_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         param_vld_ff   <= '0;
         special_vld_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         if (cmd_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_param) begin
            param_vld_ff[wr_param_addr] <= 1'b1;
         end
         if (wr_special) begin
            special_vld_ff[wr_special_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_param) begin
         param_mem[wr_param_addr] <= cmd.data;
      end
      if (wr_special) begin
         special_mem[wr_special_addr] <= cmd.data;
      end
      if (cmd_pop) begin
         param_rd_ff     <= param_mem[cur_param_addr];
         param_rdv_ff    <= param_vld_ff[cur_param_addr];
         special_rd_ff   <= special_mem[cur_special_addr];
         special_rdv_ff  <= special_vld_ff[cur_special_addr];
         from_param_ff   <= is_report && !cur_ff[CUR_W-1];
         from_special_ff <= is_report && cur_ff[CUR_W-1];
         data_ff         <= cmd.data;
         if (is_report) begin
            kind_ff  <= KIND_REPORT;
            index_ff <= 32'(cur_ff);
            time_ff  <= cmd.data;
         end else begin
            kind_ff  <= (cmd.op == CMD_DROP) ? KIND_DROPPED : KIND_STORED;
            index_ff <= cmd.index;
            time_ff  <= '0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_payload.kind        = kind_ff;
   assign rsp_payload.param_index = $signed(index_ff);
   assign rsp_payload.report_time = time_ff;
   assign rsp_payload.param_value =
      from_param_ff   ? (param_rdv_ff ? param_rd_ff : '0) :
      from_special_ff ? (special_rdv_ff ? special_rd_ff : '0) :
      data_ff;

endmodule

// ===== design/framed_parameter_receiver_reporter_top.sv =====
// ----------------------------------------------------------------------------
// framed_parameter_receiver_reporter_top
// Deframes received bytes into parameter writes and reports stored
// parameters in rotating order on each report tick.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  fprr_pkg::req_type
//   rsp       out         rsp_valid/rsp_stall  fprr_pkg::rsp_type
//
// One item is accepted per cycle while the queue is not full; a result passes
// through the command queue and then the registered store read.
// Reset clears the window count, the cursor, the queue and the store valid
// bits at once, so no clearing pass is needed.
// A stalled result holds in the output register while the queue keeps
// taking items until it fills.
// ----------------------------------------------------------------------------
module framed_parameter_receiver_reporter_top #(
   parameter int PARAM_COUNT   = fprr_pkg::PARAM_COUNT_DEFAULT,
   parameter int SPECIAL_COUNT = fprr_pkg::SPECIAL_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fprr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fprr_pkg::rsp_type rsp_payload
);
   import fprr_pkg::*;

   logic    queue_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop;

   fprr_front #(
      .PARAM_COUNT   (PARAM_COUNT),
      .SPECIAL_COUNT (SPECIAL_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   fprr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   fprr_back #(
      .PARAM_COUNT   (PARAM_COUNT),
      .SPECIAL_COUNT (SPECIAL_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd         (pop_cmd),
      .cmd_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
